@@ hw/rtl/sensor_window_average_alarm_timer_core_defines.svh @@
`ifndef SENSOR_WINDOW_AVERAGE_ALARM_TIMER_CORE_DEFINES_SVH
`define SENSOR_WINDOW_AVERAGE_ALARM_TIMER_CORE_DEFINES_SVH

// Concurrent checks on the rising edge of clk, quiet while rst_n is low.
`define SWAAT_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

`define SWAAT_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ hw/rtl/swaat_pkg.sv @@
`default_nettype none
package swaat_pkg;

  localparam int RAW_W    = 8;
  localparam int TS_W     = 32;
  localparam int NORM_W   = 18;
  localparam int SUM_W    = 22;
  localparam int COUNT_W  = 4;
  localparam int TH_W     = 16;
  localparam int RECIP_W  = 10;
  localparam int DATA_W   = 32;
  localparam int ADDR_W   = 3;

  localparam int WINDOW_DEF = 10;

  // A 26-bit shift keeps the reciprocal divide exact for any 22-bit sum
  // and any window of up to 15 items.
  localparam int DIV_SHIFT   = 26;
  localparam int DIV_RECIP_W = DIV_SHIFT + 1;

  localparam logic [RAW_W-1:0]   OFF_TEMP   = 8'd20;
  localparam logic [RAW_W-1:0]   OFF_CO     = 8'd45;
  localparam logic [RAW_W-1:0]   OFF_GAS    = 8'd25;
  localparam logic [RECIP_W-1:0] RECIP_TEMP = 10'd624;
  localparam logic [RECIP_W-1:0] RECIP_CO   = 10'd799;
  localparam logic [RECIP_W-1:0] RECIP_GAS  = 10'd643;

  localparam logic [TH_W-1:0] THRESHOLD_RESET = 16'h8000;

  // Register select, taken from paddr[2].
  localparam logic REG_ENABLE    = 1'b0;
  localparam logic REG_THRESHOLD = 1'b1;

endpackage
`default_nettype wire

@@ hw/rtl/swaat_norm.sv @@
`default_nettype none
module swaat_norm (
  input  wire logic [swaat_pkg::RAW_W-1:0]   raw,
  input  wire logic [swaat_pkg::RAW_W-1:0]   off,
  input  wire logic [swaat_pkg::RECIP_W-1:0] recip,
  output logic      [swaat_pkg::NORM_W-1:0]  norm
);
  import swaat_pkg::*;

  logic [RAW_W-1:0] diff;

  // Readings at or below the offset clamp to zero.
  always_comb begin
    diff = (raw > off) ? (raw - off) : '0;
    norm = NORM_W'(diff) * NORM_W'(recip);
  end

endmodule
`default_nettype wire

@@ hw/rtl/sensor_window_average_alarm_timer_core.sv @@
`default_nettype none
// Sensor window averager with alarm timer. Takes one transaction per clock
// cycle while in_stall is low: a transaction is registered in the input
// register on acceptance and processed from there, and its result, if any,
// is then loaded into the output register, which drives out_valid. The
// first WINDOW transactions of a window are normalized and summed and drive
// the alarm start and end times; the next one closes the window and produces
// the three Q2.16 averages and the alarm duration, then the block rearms. A
// closing transaction waits in the input register only while the output
// register holds a result that the sink stalls. With enable low, transactions
// are accepted and dropped.
module sensor_window_average_alarm_timer_core #(
  parameter int WINDOW = swaat_pkg::WINDOW_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [swaat_pkg::RAW_W-1:0]    in_temp_raw,
  input  wire logic [swaat_pkg::RAW_W-1:0]    in_co_raw,
  input  wire logic [swaat_pkg::RAW_W-1:0]    in_gas_raw,
  input  wire logic [swaat_pkg::TS_W-1:0]     in_timestamp,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic      [swaat_pkg::NORM_W-1:0]   out_avg_temp,
  output logic      [swaat_pkg::NORM_W-1:0]   out_avg_co,
  output logic      [swaat_pkg::NORM_W-1:0]   out_avg_gas,
  output logic      [swaat_pkg::TS_W-1:0]     out_duration,
  input  wire logic                           psel,
  input  wire logic                           penable,
  input  wire logic                           pwrite,
  input  wire logic [swaat_pkg::ADDR_W-1:0]   paddr,
  input  wire logic [swaat_pkg::DATA_W-1:0]   pwdata,
  output logic      [swaat_pkg::DATA_W-1:0]   prdata,
  output logic                                pready
);
  import swaat_pkg::*;

  `include "sensor_window_average_alarm_timer_core_defines.svh"

  localparam logic [COUNT_W-1:0] WINDOW_CNT = COUNT_W'(WINDOW);
  localparam logic [DIV_RECIP_W-1:0] DIV_RECIP =
    DIV_RECIP_W'(((64'd1 << DIV_SHIFT) + 64'(WINDOW) - 64'd1) / 64'(WINDOW));
  localparam int PROD_W = SUM_W + DIV_RECIP_W;

  // Configuration registers
  logic            enable_r;
  logic [TH_W-1:0] threshold_r;
  logic            cfg_wr;

  // Input register
  logic             pipe_vld_r, pipe_vld_nxt;
  logic [RAW_W-1:0] temp_r, co_r, gas_r;
  logic [TS_W-1:0]  ts_r;

  // Window state
  logic [SUM_W-1:0]   sum_temp_r, sum_temp_nxt;
  logic [SUM_W-1:0]   sum_co_r, sum_co_nxt;
  logic [SUM_W-1:0]   sum_gas_r, sum_gas_nxt;
  logic [COUNT_W-1:0] items_r, items_nxt;
  logic               start_seen_r, start_seen_nxt;
  logic               end_seen_r, end_seen_nxt;
  logic [TS_W-1:0]    start_time_r, start_time_nxt;
  logic [TS_W-1:0]    end_time_r, end_time_nxt;

  // Output register
  logic              out_valid_r, out_valid_nxt;
  logic [NORM_W-1:0] avg_temp_r, avg_co_r, avg_gas_r;
  logic [TS_W-1:0]   duration_r;

  logic              closing, active, advance, accept, out_free, out_load;
  logic [NORM_W-1:0] n_temp, n_co, n_gas;
  logic              any_above, all_below;
  logic [TS_W-1:0]   close_start, close_end;
  logic [PROD_W-1:0] prod_temp, prod_co, prod_gas;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (paddr[2])
      REG_ENABLE:    prdata = DATA_W'(enable_r);
      REG_THRESHOLD: prdata = DATA_W'(threshold_r);
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      threshold_r <= THRESHOLD_RESET;
    end else if (cfg_wr) begin
      if (paddr[2] == REG_ENABLE) begin
        enable_r <= pwdata[0];
      end else begin
        threshold_r <= pwdata[TH_W-1:0];
      end
    end
  end

  swaat_norm u_norm_temp (.raw(temp_r), .off(OFF_TEMP), .recip(RECIP_TEMP), .norm(n_temp));
  swaat_norm u_norm_co   (.raw(co_r),   .off(OFF_CO),   .recip(RECIP_CO),   .norm(n_co));
  swaat_norm u_norm_gas  (.raw(gas_r),  .off(OFF_GAS),  .recip(RECIP_GAS),  .norm(n_gas));

  always_comb begin
    closing  = (items_r >= WINDOW_CNT);
    active   = pipe_vld_r && enable_r;
    out_free = !out_valid_r || !out_stall;
    // Only a closing transaction needs the output register.
    advance  = !(active && closing) || out_free;
    in_stall = pipe_vld_r && !advance;
    accept   = in_valid && !in_stall;
    out_load = active && closing && out_free;

    pipe_vld_nxt = (pipe_vld_r && !advance) || in_valid;

    any_above = (n_temp > NORM_W'(threshold_r)) || (n_co > NORM_W'(threshold_r)) ||
                (n_gas > NORM_W'(threshold_r));
    all_below = (n_temp < NORM_W'(threshold_r)) && (n_co < NORM_W'(threshold_r)) &&
                (n_gas < NORM_W'(threshold_r));

    close_start = start_seen_r ? start_time_r : ts_r;
    close_end   = (!end_seen_r || (end_time_r < close_start)) ? ts_r : end_time_r;

    prod_temp = PROD_W'(sum_temp_r) * PROD_W'(DIV_RECIP);
    prod_co   = PROD_W'(sum_co_r) * PROD_W'(DIV_RECIP);
    prod_gas  = PROD_W'(sum_gas_r) * PROD_W'(DIV_RECIP);

    sum_temp_nxt   = sum_temp_r;
    sum_co_nxt     = sum_co_r;
    sum_gas_nxt    = sum_gas_r;
    items_nxt      = items_r;
    start_seen_nxt = start_seen_r;
    end_seen_nxt   = end_seen_r;
    start_time_nxt = start_time_r;
    end_time_nxt   = end_time_r;

    if (active && !closing) begin
      sum_temp_nxt = sum_temp_r + SUM_W'(n_temp);
      sum_co_nxt   = sum_co_r + SUM_W'(n_co);
      sum_gas_nxt  = sum_gas_r + SUM_W'(n_gas);
      items_nxt    = items_r + COUNT_W'(1);
      if (!start_seen_r && any_above) begin
        start_seen_nxt = 1'b1;
        start_time_nxt = ts_r;
      end
      if (all_below) begin
        end_seen_nxt = 1'b1;
        end_time_nxt = ts_r;
      end
    end else if (out_load) begin
      sum_temp_nxt   = '0;
      sum_co_nxt     = '0;
      sum_gas_nxt    = '0;
      items_nxt      = '0;
      start_seen_nxt = 1'b0;
      end_seen_nxt   = 1'b0;
      start_time_nxt = '0;
      end_time_nxt   = '0;
    end

    out_valid_nxt = out_load || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pipe_vld_r   <= 1'b0;
      out_valid_r  <= 1'b0;
      sum_temp_r   <= '0;
      sum_co_r     <= '0;
      sum_gas_r    <= '0;
      items_r      <= '0;
      start_seen_r <= 1'b0;
      end_seen_r   <= 1'b0;
      start_time_r <= '0;
      end_time_r   <= '0;
    end else begin
      pipe_vld_r   <= pipe_vld_nxt;
      out_valid_r  <= out_valid_nxt;
      sum_temp_r   <= sum_temp_nxt;
      sum_co_r     <= sum_co_nxt;
      sum_gas_r    <= sum_gas_nxt;
      items_r      <= items_nxt;
      start_seen_r <= start_seen_nxt;
      end_seen_r   <= end_seen_nxt;
      start_time_r <= start_time_nxt;
      end_time_r   <= end_time_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      temp_r <= in_temp_raw;
      co_r   <= in_co_raw;
      gas_r  <= in_gas_raw;
      ts_r   <= in_timestamp;
    end
    if (out_load) begin
      avg_temp_r <= prod_temp[DIV_SHIFT +: NORM_W];
      avg_co_r   <= prod_co[DIV_SHIFT +: NORM_W];
      avg_gas_r  <= prod_gas[DIV_SHIFT +: NORM_W];
      duration_r <= close_end - close_start;
    end
  end

  assign out_valid    = out_valid_r;
  assign out_avg_temp = avg_temp_r;
  assign out_avg_co   = avg_co_r;
  assign out_avg_gas  = avg_gas_r;
  assign out_duration = duration_r;

  `SWAAT_ASSERT_NOW(a_items_in_range, 1'b1, items_r <= WINDOW_CNT, "window count overran")
  `SWAAT_ASSERT_NEXT(a_rearm_after_close, out_load, (items_r == '0) && !start_seen_r && !end_seen_r, "window not rearmed after a result")
  `SWAAT_ASSERT_NOW(a_stall_needs_close, in_stall, active && closing && out_valid_r, "input stalled without a blocked closing transaction")

endmodule
`default_nettype wire

@@ tb/sv/testbench.sv @@
module testbench;
  import swaat_pkg::*;

  localparam int unsigned WIN          = WINDOW_DEF;
  localparam int          QUIET_CYCLES = 8;
  localparam int          STALL_LIMIT  = 4000;
  localparam int          PHASE_ITEMS  = 100;

  typedef struct packed {
    logic [NORM_W-1:0] avg_temp;
    logic [NORM_W-1:0] avg_co;
    logic [NORM_W-1:0] avg_gas;
    logic [TS_W-1:0]   duration;
  } window_report_t;

  logic              clk = 1'b0;
  logic              rst_n = 1'b0;
  logic              in_valid = 1'b0;
  logic              in_stall;
  logic [RAW_W-1:0]  in_temp_raw = '0;
  logic [RAW_W-1:0]  in_co_raw = '0;
  logic [RAW_W-1:0]  in_gas_raw = '0;
  logic [TS_W-1:0]   in_timestamp = '0;
  logic              out_valid;
  logic              out_stall = 1'b0;
  logic [NORM_W-1:0] out_avg_temp;
  logic [NORM_W-1:0] out_avg_co;
  logic [NORM_W-1:0] out_avg_gas;
  logic [TS_W-1:0]   out_duration;
  logic              psel = 1'b0;
  logic              penable = 1'b0;
  logic              pwrite = 1'b0;
  logic [ADDR_W-1:0] paddr = '0;
  logic [DATA_W-1:0] pwdata = '0;
  logic [DATA_W-1:0] prdata;
  logic              pready;

  // Predicted block state and register copies.
  logic              pred_enable = 1'b0;
  logic [TH_W-1:0]   pred_threshold = THRESHOLD_RESET;
  logic [SUM_W-1:0]  acc_temp = '0;
  logic [SUM_W-1:0]  acc_co = '0;
  logic [SUM_W-1:0]  acc_gas = '0;
  int unsigned       window_fill = 0;
  bit                alarm_started = 1'b0;
  bit                alarm_cleared = 1'b0;
  logic [TS_W-1:0]   alarm_start_ts = '0;
  logic [TS_W-1:0]   alarm_end_ts = '0;
  window_report_t    reports_due[$];

  int unsigned       errors = 0;
  int unsigned       readings_taken = 0;
  int unsigned       reports_checked = 0;
  int unsigned       quiet_cycles = 0;
  int unsigned       send_idle_pct = 0;
  int unsigned       sink_stall_pct = 0;
  logic [TS_W-1:0]   tick_now = '0;

  sensor_window_average_alarm_timer_core dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_temp_raw  (in_temp_raw),
    .in_co_raw    (in_co_raw),
    .in_gas_raw   (in_gas_raw),
    .in_timestamp (in_timestamp),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_avg_temp (out_avg_temp),
    .out_avg_co   (out_avg_co),
    .out_avg_gas  (out_avg_gas),
    .out_duration (out_duration),
    .psel         (psel),
    .penable      (penable),
    .pwrite       (pwrite),
    .paddr        (paddr),
    .pwdata       (pwdata),
    .prdata       (prdata),
    .pready       (pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic logic [NORM_W-1:0] scaled_reading(logic [RAW_W-1:0] raw,
                                                       logic [RAW_W-1:0] offset,
                                                       logic [RECIP_W-1:0] recip);
    logic [NORM_W-1:0] diff;
    if (raw <= offset) return '0;
    diff = NORM_W'(raw - offset);
    return NORM_W'(diff * recip);
  endfunction

  // Advances the predicted window by one accepted transaction and queues the
  // report when the transaction closes a window.
  task automatic absorb_reading(input logic [RAW_W-1:0] t_raw, c_raw, g_raw,
                                input logic [TS_W-1:0] ts);
    logic [NORM_W-1:0] t, c, g, th;
    window_report_t rep;
    if (!pred_enable) return;
    if (window_fill < WIN) begin
      t  = scaled_reading(t_raw, OFF_TEMP, RECIP_TEMP);
      c  = scaled_reading(c_raw, OFF_CO, RECIP_CO);
      g  = scaled_reading(g_raw, OFF_GAS, RECIP_GAS);
      th = NORM_W'(pred_threshold);
      if (!alarm_started && (t > th || c > th || g > th)) begin
        alarm_start_ts = ts;
        alarm_started  = 1'b1;
      end
      if (t < th && c < th && g < th) begin
        alarm_end_ts  = ts;
        alarm_cleared = 1'b1;
      end
      acc_temp = acc_temp + SUM_W'(t);
      acc_co   = acc_co + SUM_W'(c);
      acc_gas  = acc_gas + SUM_W'(g);
      window_fill++;
    end else begin
      if (!alarm_started) alarm_start_ts = ts;
      if (!alarm_cleared || alarm_end_ts < alarm_start_ts) alarm_end_ts = ts;
      rep.avg_temp = NORM_W'(acc_temp / WIN);
      rep.avg_co   = NORM_W'(acc_co / WIN);
      rep.avg_gas  = NORM_W'(acc_gas / WIN);
      rep.duration = alarm_end_ts - alarm_start_ts;
      reports_due = {reports_due, rep};
      acc_temp       = '0;
      acc_co         = '0;
      acc_gas        = '0;
      window_fill    = 0;
      alarm_started  = 1'b0;
      alarm_cleared  = 1'b0;
      alarm_start_ts = '0;
      alarm_end_ts   = '0;
    end
  endtask

  task automatic check_field(input string name, input logic [31:0] want, got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endtask

  always @(posedge clk) begin : window_checker
    window_report_t want;
    if (rst_n) begin
      if (in_valid && !in_stall) begin
        readings_taken++;
        absorb_reading(in_temp_raw, in_co_raw, in_gas_raw, in_timestamp);
      end
      if (out_valid && !out_stall) begin
        if (reports_due.size() == 0) begin
          errors++;
          $display("%0t: unexpected report, expected none, actual %0d %0d %0d %0d",
                   $time, out_avg_temp, out_avg_co, out_avg_gas, out_duration);
        end else begin
          want = reports_due.pop_front();
          reports_checked++;
          check_field("avg_temp", 32'(want.avg_temp), 32'(out_avg_temp));
          check_field("avg_co", 32'(want.avg_co), 32'(out_avg_co));
          check_field("avg_gas", 32'(want.avg_gas), 32'(out_avg_gas));
          check_field("duration", want.duration, out_duration);
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && !((in_valid && !in_stall) || (out_valid && !out_stall))) begin
      quiet_cycles++;
      if (quiet_cycles >= STALL_LIMIT) begin
        $display("%0t: no transaction for %0d cycles", $time, STALL_LIMIT);
        $display("FAILED: results differ");
        $finish;
      end
    end else begin
      quiet_cycles = 0;
    end
  end

  always @(posedge clk) out_stall <= ($urandom_range(99) < sink_stall_pct);

  task automatic send_reading(input logic [RAW_W-1:0] t_raw, c_raw, g_raw,
                              input logic [TS_W-1:0] ts);
    int gap;
    gap = 0;
    while (gap < 20 && $urandom_range(99) < send_idle_pct) gap++;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_temp_raw  <= t_raw;
    in_co_raw    <= c_raw;
    in_gas_raw   <= g_raw;
    in_timestamp <= ts;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // Waits until every queued report has come out, then lets the block's
  // pipeline empty so that a register write cannot overlap a transaction.
  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (reports_due.size() != 0) @(posedge clk);
    repeat (QUIET_CYCLES) @(posedge clk);
  endtask

  task automatic write_register(input logic reg_sel, input logic [DATA_W-1:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= ADDR_W'({reg_sel, 2'b00});
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_ENABLE) pred_enable = value[0];
    else pred_threshold = value[TH_W-1:0];
    @(posedge clk);
  endtask

  function automatic logic [RAW_W-1:0] pick_raw(logic [RAW_W-1:0] offset);
    case ($urandom_range(3))
      0, 1:    return RAW_W'($urandom_range(255));
      2:       return RAW_W'($urandom_range(offset + 70));
      default: return RAW_W'($urandom_range(offset + 10));
    endcase
  endfunction

  function automatic logic [TS_W-1:0] next_tick();
    if ($urandom_range(19) == 0) tick_now = $urandom();
    else tick_now = tick_now + $urandom_range(1, 500);
    return tick_now;
  endfunction

  task automatic test_disabled_drops();
    repeat (3) send_reading(8'd255, 8'd255, 8'd255, next_tick());
    settle_block();
  endtask

  // Raw extremes and readings at and just past the offsets, with the
  // threshold at full scale and an alarm window that wraps the tick counter.
  task automatic test_extreme_readings();
    logic [RAW_W-1:0] temps[10] = '{0, 255, 20, 21, 255, 0, 19, 128, 255, 1};
    logic [RAW_W-1:0] cos[10]   = '{0, 255, 45, 46, 0, 255, 44, 128, 255, 1};
    logic [RAW_W-1:0] gases[10] = '{0, 255, 25, 26, 255, 0, 24, 128, 255, 1};
    logic [TS_W-1:0]  ticks[10] = '{32'h0, 32'hFFFF_FFF0, 32'h8, 32'h9, 32'hA,
                                    32'hB, 32'h10, 32'hC, 32'hD, 32'h0E};
    write_register(REG_ENABLE, 32'h0000_0001);
    write_register(REG_THRESHOLD, 32'hFFFF_FFFF);
    for (int i = 0; i < 10; i++) send_reading(temps[i], cos[i], gases[i], ticks[i]);
    send_reading(8'd255, 8'd255, 8'd255, 32'h20);
    settle_block();
  endtask

  // A temperature reading exactly at the threshold neither starts the alarm
  // nor counts as below it; the alarm starts after the last quiet reading.
  task automatic test_threshold_ties();
    write_register(REG_THRESHOLD, 32'(50 * 624));
    send_reading(8'd0, 8'd0, 8'd0, 32'd100);
    send_reading(8'd70, 8'd0, 8'd0, 32'd200);
    send_reading(8'd255, 8'd0, 8'd0, 32'd300);
    for (int i = 0; i < 7; i++) send_reading(8'd70, OFF_CO, OFF_GAS, 32'(400 + i));
    send_reading(8'd255, 8'd255, 8'd255, 32'd5000);
    settle_block();
  endtask

  task automatic test_random_traffic();
    logic [TH_W-1:0] levels[5];
    for (int mode = 0; mode < 3; mode++) begin
      send_idle_pct  = (mode == 0) ? 36 : (mode == 1) ? 48 : 0;
      sink_stall_pct = (mode == 0) ? 48 : (mode == 1) ? 36 : 0;
      levels = '{16'h0000, 16'hFFFF, THRESHOLD_RESET, TH_W'($urandom()), TH_W'($urandom())};
      for (int p = 0; p < 5; p++) begin
        write_register(REG_THRESHOLD, {16'($urandom_range(65535)), levels[p]});
        repeat (PHASE_ITEMS)
          send_reading(pick_raw(OFF_TEMP), pick_raw(OFF_CO), pick_raw(OFF_GAS), next_tick());
        settle_block();
      end
      // A short disabled stretch in the middle of a window; the partial
      // window must survive it untouched.
      write_register(REG_ENABLE, $urandom() & 32'hFFFF_FFFE);
      repeat (10) send_reading(RAW_W'($urandom()), RAW_W'($urandom()), RAW_W'($urandom()),
                               next_tick());
      settle_block();
      write_register(REG_ENABLE, $urandom() | 32'h1);
    end
  endtask

  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_disabled_drops();
    test_extreme_readings();
    test_threshold_ties();
    test_random_traffic();
    settle_block();
    $display("Checked %0d window reports from %0d accepted readings.",
             reports_checked, readings_taken);
    $display("Covered raw extremes, threshold ties and sweeps, disabled gaps and stalls.");
    if (errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule
